### design/smfx_pkg.sv
// ============================================================================
// smfx_pkg
// Shared types and constants for the serial message framer: byte codes,
// result kinds, receive phases and the job record passed front to back.
// ============================================================================
package smfx_pkg;

    // Framing bytes
    localparam logic [7:0] START_BYTE = 8'h1b;
    localparam logic [7:0] TOKEN_BYTE = 8'h0e;
    localparam logic [7:0] SEQ_MAX    = 8'hff;
    localparam logic [7:0] SEQ_FIRST  = 8'h01;
    localparam logic [7:0] TAIL_BYTE  = 8'h00;

    // Input command codes
    localparam logic CMD_TX = 1'b0;
    localparam logic CMD_RX = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_LINE   = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_GOOD   = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    // Transmit byte positions inside one job
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_SEQ   = 3'd1;
    localparam logic [2:0] POS_LENHI = 3'd2;
    localparam logic [2:0] POS_LENLO = 3'd3;
    localparam logic [2:0] POS_TOKEN = 3'd4;
    localparam logic [2:0] POS_DATA  = 3'd5;
    localparam logic [2:0] POS_SUM   = 3'd6;
    localparam logic [2:0] POS_TAIL  = 3'd7;

    // Default depth of the job queue
    localparam int QUEUE_DEPTH = 4;

    // Receive phases, one-hot
    typedef enum logic [6:0] {
        PH_HUNT  = 7'b0000001,
        PH_SEQ   = 7'b0000010,
        PH_LENHI = 7'b0000100,
        PH_LENLO = 7'b0001000,
        PH_TOKEN = 7'b0010000,
        PH_BODY  = 7'b0100000,
        PH_SUM   = 7'b1000000
    } rx_phase_t;

    // One classified item: a transmit burst or a single receive result
    typedef struct packed {
        logic        rx;      // single receive result
        logic        hdr;     // emit the five header bytes
        logic        body;    // emit the payload byte
        logic        tail;    // emit checksum and trailing zero
        logic [1:0]  kind;    // receive result kind
        logic [7:0]  seq;
        logic [15:0] len;     // tx header length or rx message length
        logic [7:0]  data;    // payload or body byte
        logic [7:0]  csum;    // transmit checksum
    } job_t;

endpackage

### design/serial_message_framer_xor.sv
// ============================================================================
// serial_message_framer_xor
// Link framer with transmit and receive directions sharing one sequence number.
// ----------------------------------------------------------------------------
// Input stream (s_*): one item per transfer. s_tuser selects transmit payload
// byte or received line byte; s_tdata carries the byte and, for the first
// transmit byte of a message, its length.
// Output stream (m_*): one result per transfer. m_tuser gives the kind (line
// byte, received body byte, end good, end bad); m_tlast marks the final result
// caused by one input item.
// With the block idle, the first result of an item passes through the job
// queue, the current-job register and the output register before m_tvalid
// rises. Results leave at one per cycle while m_tready is high; an item
// causes zero to eight results, and the output register holds one result at
// a time. A first transmit byte of a message with one payload byte causes eight.
// The front end classifies items into a job queue (QUEUE_DEPTH entries);
// s_tready drops only when the queue is full, so the input keeps flowing while
// the receiver stalls, until the queue fills. The output register holds its
// result while m_tready is low.
// Reset clears the sequence number, counts, checksums, receive hunt state,
// the queue and the output stage.
// ============================================================================
module serial_message_framer_xor
#(
    parameter int QUEUE_DEPTH = smfx_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_in[7:0], tx_length[23:8]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_out[7:0], rx_length[23:8]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    smfx_pkg::job_t wr_job;
    smfx_pkg::job_t rd_job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classify items and keep link state
    smfx_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (s_tuser[0]),
        .data_in   (s_tdata[7:0]),
        .tx_length (s_tdata[23:8]),
        .push      (push),
        .job       (wr_job)
    );

    // Decouple front and back
    smfx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Expand jobs into result bytes
    smfx_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (rd_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### design/smfx_front.sv
// ============================================================================
// smfx_front
// Accepts items, keeps the link state (sequence, counts, checksums, receive
// phase) and turns each item into a job record for the back end.
// ============================================================================
module smfx_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               command,
    input  logic [7:0]         data_in,
    input  logic [15:0]        tx_length,
    output logic               push,
    output smfx_pkg::job_t     job
);

    logic [7:0]          seq_reg,      seq_next;
    logic [15:0]         tx_rem_reg,   tx_rem_next;
    logic [7:0]          tx_cs_reg,    tx_cs_next;
    smfx_pkg::rx_phase_t rx_phase_reg, rx_phase_next;
    logic [15:0]         rx_len_reg,   rx_len_next;
    logic [15:0]         rx_cnt_reg,   rx_cnt_next;
    logic [7:0]          rx_cs_reg,    rx_cs_next;

    logic [7:0]  seq_step;
    logic [7:0]  hdr_cs;
    logic [15:0] rem_dec;
    logic [15:0] cnt_inc;

    // Precompute the next sequence number and header checksum
    always_comb
    begin
        seq_step = (seq_reg == smfx_pkg::SEQ_MAX) ? smfx_pkg::SEQ_FIRST : seq_reg + 8'd1;
        hdr_cs   = smfx_pkg::START_BYTE ^ seq_step ^ tx_length[15:8] ^ tx_length[7:0]
                   ^ smfx_pkg::TOKEN_BYTE;
        rem_dec  = ((tx_rem_reg == 16'd0) ? tx_length : tx_rem_reg) - 16'd1;
        cnt_inc  = rx_cnt_reg + 16'd1;
    end

    // Classify the item and step the link state
    always_comb
    begin
        seq_next      = seq_reg;
        tx_rem_next   = tx_rem_reg;
        tx_cs_next    = tx_cs_reg;
        rx_phase_next = rx_phase_reg;
        rx_len_next   = rx_len_reg;
        rx_cnt_next   = rx_cnt_reg;
        rx_cs_next    = rx_cs_reg;
        push          = 1'b0;
        job           = '0;
        job.seq       = seq_step;
        job.len       = tx_length;
        job.data      = data_in;

        if (accept)
        begin
            if (command == smfx_pkg::CMD_TX)
            begin
                push = 1'b1;
                if (tx_rem_reg == 16'd0)
                begin
                    seq_next = seq_step;
                    job.hdr  = 1'b1;
                    if (tx_length == 16'd0)
                    begin
                        job.tail   = 1'b1;
                        job.csum   = hdr_cs;
                        tx_cs_next = hdr_cs;
                    end
                    else
                    begin
                        job.body    = 1'b1;
                        job.tail    = (rem_dec == 16'd0);
                        job.csum    = hdr_cs ^ data_in;
                        tx_cs_next  = hdr_cs ^ data_in;
                        tx_rem_next = rem_dec;
                    end
                end
                else
                begin
                    job.body    = 1'b1;
                    job.tail    = (rem_dec == 16'd0);
                    job.csum    = tx_cs_reg ^ data_in;
                    tx_cs_next  = tx_cs_reg ^ data_in;
                    tx_rem_next = rem_dec;
                end
            end
            else
            begin
                job.rx  = 1'b1;
                job.len = '0;
                case (rx_phase_reg)
                    smfx_pkg::PH_SEQ:
                    begin
                        if (data_in == seq_reg)
                        begin
                            rx_cs_next    = smfx_pkg::START_BYTE ^ data_in;
                            rx_phase_next = smfx_pkg::PH_LENHI;
                        end
                        else if (data_in != smfx_pkg::START_BYTE)
                        begin
                            rx_phase_next = smfx_pkg::PH_HUNT;
                        end
                    end
                    smfx_pkg::PH_LENHI:
                    begin
                        rx_cs_next    = rx_cs_reg ^ data_in;
                        rx_len_next   = {data_in, 8'd0};
                        rx_phase_next = smfx_pkg::PH_LENLO;
                    end
                    smfx_pkg::PH_LENLO:
                    begin
                        rx_cs_next    = rx_cs_reg ^ data_in;
                        rx_len_next   = {rx_len_reg[15:8], data_in};
                        rx_phase_next = smfx_pkg::PH_TOKEN;
                    end
                    smfx_pkg::PH_TOKEN:
                    begin
                        rx_cs_next    = rx_cs_reg ^ data_in;
                        rx_cnt_next   = '0;
                        rx_phase_next = (rx_len_reg == 16'd0) ? smfx_pkg::PH_SUM
                                                              : smfx_pkg::PH_BODY;
                    end
                    smfx_pkg::PH_BODY:
                    begin
                        rx_cs_next  = rx_cs_reg ^ data_in;
                        rx_cnt_next = cnt_inc;
                        push        = 1'b1;
                        job.kind    = smfx_pkg::KIND_BODY;
                        if (cnt_inc >= rx_len_reg)
                        begin
                            rx_phase_next = smfx_pkg::PH_SUM;
                        end
                    end
                    smfx_pkg::PH_SUM:
                    begin
                        push          = 1'b1;
                        job.kind      = (data_in == rx_cs_reg) ? smfx_pkg::KIND_GOOD
                                                               : smfx_pkg::KIND_BAD;
                        job.data      = '0;
                        job.len       = rx_len_reg;
                        rx_phase_next = smfx_pkg::PH_HUNT;
                    end
                    default:
                    begin
                        rx_phase_next = (data_in == smfx_pkg::START_BYTE) ? smfx_pkg::PH_SEQ
                                                                         : smfx_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    // Hold the link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= '0;
            tx_rem_reg   <= '0;
            tx_cs_reg    <= '0;
            rx_phase_reg <= smfx_pkg::PH_HUNT;
            rx_len_reg   <= '0;
            rx_cnt_reg   <= '0;
            rx_cs_reg    <= '0;
        end
        else
        begin
            seq_reg      <= seq_next;
            tx_rem_reg   <= tx_rem_next;
            tx_cs_reg    <= tx_cs_next;
            rx_phase_reg <= rx_phase_next;
            rx_len_reg   <= rx_len_next;
            rx_cnt_reg   <= rx_cnt_next;
            rx_cs_reg    <= rx_cs_next;
        end
    end

endmodule

### design/smfx_queue.sv
// ============================================================================
// smfx_queue
// Small job queue between front and back end so each side stalls on its own.
// ============================================================================
module smfx_queue
#(
    parameter int DEPTH = smfx_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  smfx_pkg::job_t     wr_job,
    input  logic               pop,
    output smfx_pkg::job_t     rd_job,
    output logic               full,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    smfx_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

### design/smfx_back.sv
// ============================================================================
// smfx_back
// Expands each job into its result bytes, one per cycle, into an output
// register that holds while the receiver stalls.
// ============================================================================
module smfx_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  smfx_pkg::job_t     job,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // data_out[7:0], rx_length[23:8]
    output logic [1:0]         m_tuser,   // kind[1:0]
    output logic               m_tlast
);

    smfx_pkg::job_t cur_reg;
    logic           cur_valid_reg, cur_valid_next;
    logic [2:0]     pos_reg,       pos_next;
    logic           out_valid_reg, out_valid_next;
    logic [23:0]    out_data_reg;
    logic [1:0]     out_kind_reg;
    logic           out_last_reg;

    logic           advance;
    logic           take;
    logic           load;
    logic           cur_last;
    logic [2:0]     pos_after;
    logic [2:0]     pos_first;
    logic [7:0]     res_byte;
    logic [23:0]    res_data;
    logic [1:0]     res_kind;

    // Pick the byte of the current position and the position after it
    always_comb
    begin
        case (pos_reg)
            smfx_pkg::POS_START: res_byte = smfx_pkg::START_BYTE;
            smfx_pkg::POS_SEQ:   res_byte = cur_reg.seq;
            smfx_pkg::POS_LENHI: res_byte = cur_reg.len[15:8];
            smfx_pkg::POS_LENLO: res_byte = cur_reg.len[7:0];
            smfx_pkg::POS_TOKEN: res_byte = smfx_pkg::TOKEN_BYTE;
            smfx_pkg::POS_DATA:  res_byte = cur_reg.data;
            smfx_pkg::POS_SUM:   res_byte = cur_reg.csum;
            default:             res_byte = smfx_pkg::TAIL_BYTE;
        endcase

        case (pos_reg)
            smfx_pkg::POS_TOKEN: pos_after = cur_reg.body ? smfx_pkg::POS_DATA
                                                          : smfx_pkg::POS_SUM;
            smfx_pkg::POS_DATA:  pos_after = smfx_pkg::POS_SUM;
            default:             pos_after = pos_reg + 3'd1;
        endcase

        pos_first = job.hdr  ? smfx_pkg::POS_START :
                    job.body ? smfx_pkg::POS_DATA  : smfx_pkg::POS_SUM;

        cur_last = cur_reg.rx || (pos_reg == smfx_pkg::POS_TAIL)
                   || ((pos_reg == smfx_pkg::POS_DATA) && !cur_reg.tail);

        if (cur_reg.rx)
        begin
            res_kind = cur_reg.kind;
            res_data = {cur_reg.len, cur_reg.data};
        end
        else
        begin
            res_kind = smfx_pkg::KIND_LINE;
            res_data = {16'd0, res_byte};
        end
    end

    // Step through the job when the output register frees up
    always_comb
    begin
        advance        = !out_valid_reg || m_tready;
        take           = advance && cur_valid_reg;
        load           = job_valid && (!cur_valid_reg || (take && cur_last));
        pop            = load;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            pos_next = pos_after;
            if (cur_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (load)
        begin
            cur_valid_next = 1'b1;
            pos_next       = pos_first;
        end
        if (advance)
        begin
            out_valid_next = cur_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the job and the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= job;
        end
        if (take)
        begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
            out_last_reg <= cur_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

### dv/smfx_frame_checker.sv
// ============================================================================
// smfx_frame_checker
// Watches both streams of the serial message framer, works out the results
// each accepted item must cause, and compares every result transfer with the
// oldest one still due, field by field.
// ============================================================================
module smfx_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // data_in[7:0], tx_length[23:8]
    input  logic [0:0]  s_tuser,   // command[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // data_out[7:0], rx_length[23:8]
    input  logic [1:0]  m_tuser,   // kind[1:0]
    input  logic        m_tlast,
    output int          errors,
    output int          waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] msg_len;
        logic        last;
    } framer_result_t;

    // Results still due, oldest first
    framer_result_t due_q[$];

    // Shadow of the framer state
    logic [7:0]          seq_num;
    logic [15:0]         send_left;
    logic [7:0]          send_sum;
    smfx_pkg::rx_phase_t rcv_phase;
    logic [15:0]         rcv_len;
    logic [15:0]         rcv_cnt;
    logic [7:0]          rcv_sum;

    framer_result_t got;
    framer_result_t want;
    int             base_count;

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] exp_v);
        $display("%0t: %s: got %0h, expected %0h", $realtime, what, got_v, exp_v);
        errors++;
    endtask

    task automatic queue_result(input logic [1:0] kind, input logic [7:0] data,
                                input logic [15:0] msg_len);
        framer_result_t r;
        r.kind    = kind;
        r.data    = data;
        r.msg_len = msg_len;
        r.last    = 1'b0;
        due_q.push_back(r);
    endtask

    // Emit one line byte and fold it into the transmit checksum
    task automatic queue_line(input logic [7:0] b);
        send_sum = send_sum ^ b;
        queue_result(smfx_pkg::KIND_LINE, b, 16'd0);
    endtask

    task automatic predict_send(input logic [7:0] b, input logic [15:0] len);
        logic keep_byte;
        keep_byte = 1'b1;
        // open a new message: step sequence, emit header
        if (send_left == 16'd0) begin
            seq_num  = (seq_num == smfx_pkg::SEQ_MAX) ? smfx_pkg::SEQ_FIRST
                                                      : seq_num + 8'd1;
            send_sum = 8'h00;
            queue_line(smfx_pkg::START_BYTE);
            queue_line(seq_num);
            queue_line(len[15:8]);
            queue_line(len[7:0]);
            queue_line(smfx_pkg::TOKEN_BYTE);
            if (len == 16'd0) begin
                // empty message closes at once, payload byte is dropped
                queue_result(smfx_pkg::KIND_LINE, send_sum, 16'd0);
                queue_result(smfx_pkg::KIND_LINE, smfx_pkg::TAIL_BYTE, 16'd0);
                keep_byte = 1'b0;
            end
            else begin
                send_left = len;
            end
        end
        if (keep_byte) begin
            queue_line(b);
            send_left = send_left - 16'd1;
            if (send_left == 16'd0) begin
                queue_result(smfx_pkg::KIND_LINE, send_sum, 16'd0);
                queue_result(smfx_pkg::KIND_LINE, smfx_pkg::TAIL_BYTE, 16'd0);
            end
        end
    endtask

    task automatic predict_receive(input logic [7:0] b);
        case (rcv_phase)
            smfx_pkg::PH_SEQ:
            begin
                // a repeated start byte keeps the hunt armed
                if (b == seq_num) begin
                    rcv_sum   = smfx_pkg::START_BYTE ^ b;
                    rcv_phase = smfx_pkg::PH_LENHI;
                end
                else if (b != smfx_pkg::START_BYTE) begin
                    rcv_phase = smfx_pkg::PH_HUNT;
                end
            end
            smfx_pkg::PH_LENHI:
            begin
                rcv_sum   = rcv_sum ^ b;
                rcv_len   = {b, 8'h00};
                rcv_phase = smfx_pkg::PH_LENLO;
            end
            smfx_pkg::PH_LENLO:
            begin
                rcv_sum   = rcv_sum ^ b;
                rcv_len   = {rcv_len[15:8], b};
                rcv_phase = smfx_pkg::PH_TOKEN;
            end
            smfx_pkg::PH_TOKEN:
            begin
                // token is not checked, only summed
                rcv_sum   = rcv_sum ^ b;
                rcv_cnt   = 16'd0;
                rcv_phase = (rcv_len == 16'd0) ? smfx_pkg::PH_SUM : smfx_pkg::PH_BODY;
            end
            smfx_pkg::PH_BODY:
            begin
                rcv_sum = rcv_sum ^ b;
                rcv_cnt = rcv_cnt + 16'd1;
                queue_result(smfx_pkg::KIND_BODY, b, 16'd0);
                if (rcv_cnt >= rcv_len)
                    rcv_phase = smfx_pkg::PH_SUM;
            end
            smfx_pkg::PH_SUM:
            begin
                queue_result((b == rcv_sum) ? smfx_pkg::KIND_GOOD : smfx_pkg::KIND_BAD,
                             8'h00, rcv_len);
                rcv_phase = smfx_pkg::PH_HUNT;
            end
            default:
            begin
                rcv_phase = (b == smfx_pkg::START_BYTE) ? smfx_pkg::PH_SEQ
                                                        : smfx_pkg::PH_HUNT;
            end
        endcase
    endtask

    // Compare results, then predict from the accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            due_q.delete();
            seq_num   = 8'h00;
            send_left = 16'd0;
            send_sum  = 8'h00;
            rcv_phase = smfx_pkg::PH_HUNT;
            rcv_len   = 16'd0;
            rcv_cnt   = 16'd0;
            rcv_sum   = 8'h00;
            errors    = 0;
            waiting   = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.kind    = m_tuser;
                got.data    = m_tdata[7:0];
                got.msg_len = m_tdata[23:8];
                got.last    = m_tlast;
                if (due_q.size() == 0) begin
                    report_mismatch("result transfer with nothing due", 32'(got), 32'd0);
                end
                else begin
                    want = due_q.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                    if (got.data !== want.data)
                        report_mismatch("data_out", 32'(got.data), 32'(want.data));
                    if (got.msg_len !== want.msg_len)
                        report_mismatch("rx_length", 32'(got.msg_len), 32'(want.msg_len));
                    if (got.last !== want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
            end

            if (s_tvalid && s_tready) begin
                base_count = due_q.size();
                if (s_tuser[0] == smfx_pkg::CMD_RX)
                    predict_receive(s_tdata[7:0]);
                else
                    predict_send(s_tdata[7:0], s_tdata[23:8]);
                // mark the final result of this item
                if (due_q.size() > base_count) begin
                    want      = due_q[due_q.size() - 1];
                    want.last = 1'b1;
                    due_q[due_q.size() - 1] = want;
                end
            end

            waiting = due_q.size();
        end
    end

endmodule

### dv/tb.sv
// ============================================================================
// tb
// Stimulus for the serial message framer: directed extremes and special
// cases, then random messages, frames and line noise under several idle and
// stall patterns.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 40;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // data_in[7:0], tx_length[23:8]
    logic [0:0]  s_tuser  = '0;   // command[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // data_out[7:0], rx_length[23:8]
    logic [1:0]  m_tuser;         // kind[1:0]
    logic        m_tlast;

    int errors;
    int waiting;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int item_count  = 0;

    // Sequence number the framer should hold after the last message sent
    logic [7:0] tx_seq = 8'h00;

    serial_message_framer_xor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    smfx_frame_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .waiting  (waiting)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result stream at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_message_framer_xor: mismatch");
            $finish;
        end
    end

    // Hold one item on the input until its transfer
    task automatic push_item(input logic cmd, input logic [7:0] b, input logic [15:0] len);
        while ($urandom_range(99, 0) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {len, b};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        item_count++;
    endtask

    // Send a whole message; later bytes carry junk lengths that must be ignored
    task automatic send_message(input logic [15:0] len, input logic [7:0] first,
                                input bit mixed);
        int         n;
        logic [7:0] noise;
        n      = (len == 16'd0) ? 1 : int'(len);
        tx_seq = (tx_seq == smfx_pkg::SEQ_MAX) ? smfx_pkg::SEQ_FIRST : tx_seq + 8'd1;
        push_item(smfx_pkg::CMD_TX, first, len);
        for (int i = 1; i < n; i++) begin
            // slip in a line byte that cannot arm the hunt
            if (mixed && $urandom_range(99, 0) < 15) begin
                noise = 8'($urandom);
                if (noise == smfx_pkg::START_BYTE)
                    noise = 8'h00;
                push_item(smfx_pkg::CMD_RX, noise, 16'($urandom));
            end
            push_item(smfx_pkg::CMD_TX, 8'($urandom), 16'($urandom));
        end
    endtask

    // Send a received frame addressed to the current sequence number
    task automatic send_frame(input logic [15:0] len, input bit bad_sum,
                              input logic [7:0] token);
        logic [7:0] sum;
        logic [7:0] b;
        sum = smfx_pkg::START_BYTE ^ tx_seq ^ len[15:8] ^ len[7:0] ^ token;
        push_item(smfx_pkg::CMD_RX, smfx_pkg::START_BYTE, 16'($urandom));
        push_item(smfx_pkg::CMD_RX, tx_seq, 16'($urandom));
        push_item(smfx_pkg::CMD_RX, len[15:8], 16'($urandom));
        push_item(smfx_pkg::CMD_RX, len[7:0], 16'($urandom));
        push_item(smfx_pkg::CMD_RX, token, 16'($urandom));
        for (int i = 0; i < int'(len); i++) begin
            b   = 8'($urandom);
            sum = sum ^ b;
            push_item(smfx_pkg::CMD_RX, b, 16'($urandom));
        end
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(255, 1));
        push_item(smfx_pkg::CMD_RX, sum, 16'($urandom));
    endtask

    // Hold the input until every due result has arrived, then settle
    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic run_phase(input int idle, input int stall);
        int         first_item;
        int         pick;
        logic [7:0] b;
        idle_pct   = idle;
        stall_pct  = stall;
        first_item = item_count;
        while (item_count - first_item < PHASE_ITEMS) begin
            pick = $urandom_range(99, 0);
            if (pick < 40) begin
                send_message(($urandom_range(19, 0) == 0) ? 16'd0 : 16'($urandom_range(6, 1)),
                             8'($urandom), 1'b1);
            end
            else if (pick < 80) begin
                send_frame(16'($urandom_range(5, 0)), $urandom_range(9, 0) == 0,
                           ($urandom_range(9, 0) == 0) ? 8'($urandom) : smfx_pkg::TOKEN_BYTE);
            end
            else if (pick < 88) begin
                // stray byte while hunting
                b = 8'($urandom);
                if (b == smfx_pkg::START_BYTE)
                    b = 8'h00;
                push_item(smfx_pkg::CMD_RX, b, 16'($urandom));
            end
            else if (pick < 94) begin
                // start byte followed by a foreign sequence number
                b = 8'($urandom);
                while (b == tx_seq || b == smfx_pkg::START_BYTE)
                    b = 8'($urandom);
                push_item(smfx_pkg::CMD_RX, smfx_pkg::START_BYTE, 16'($urandom));
                push_item(smfx_pkg::CMD_RX, b, 16'($urandom));
            end
            else begin
                // doubled start byte restarts the hunt
                push_item(smfx_pkg::CMD_RX, smfx_pkg::START_BYTE, 16'($urandom));
                send_frame(16'($urandom_range(5, 0)), 1'b0, smfx_pkg::TOKEN_BYTE);
            end
        end
        drain(DRAIN_CYCLES);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // transmit extremes, empty message, junk length mid-message
        send_message(16'd1, 8'h00, 1'b0);
        send_message(16'd0, 8'hff, 1'b0);
        send_message(16'd2, 8'hff, 1'b0);

        // line noise, doubled start, foreign sequence, token and checksum cases
        push_item(smfx_pkg::CMD_RX, 8'h00, 16'h0000);
        push_item(smfx_pkg::CMD_RX, 8'hff, 16'hffff);
        push_item(smfx_pkg::CMD_RX, smfx_pkg::START_BYTE, 16'h0000);
        send_frame(16'd1, 1'b0, smfx_pkg::TOKEN_BYTE);
        push_item(smfx_pkg::CMD_RX, smfx_pkg::START_BYTE, 16'hffff);
        push_item(smfx_pkg::CMD_RX, tx_seq ^ 8'h01, 16'h0000);
        send_frame(16'd0, 1'b1, 8'hff);
        send_frame(16'd0, 1'b0, smfx_pkg::TOKEN_BYTE);
        send_frame(16'd2, 1'b0, 8'h00);
        drain(DRAIN_CYCLES);

        run_phase(0, 0);
        run_phase(76, 0);
        run_phase(0, 76);
        run_phase(29, 29);

        if (errors == 0)
            $display("serial_message_framer_xor: match");
        else
            $display("serial_message_framer_xor: mismatch");
        $finish;
    end

endmodule
